### design/psrl_pkg.sv
// Shared types and constants for the per-source request limiter.
package psrl_pkg;

  localparam int unsigned DEFAULT_TABLE_ENTRIES = 256;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned LIMIT_W       = 16;
  localparam int unsigned UNIQUE_W      = 9;
  localparam int unsigned CFG_INDEX_W   = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'd65535;

  // Request actions.
  localparam logic [1:0] ACT_INC       = 2'd0;
  localparam logic [1:0] ACT_INC_CHECK = 2'd1;
  localparam logic [1:0] ACT_CHECK     = 2'd2;
  localparam logic [1:0] ACT_CLEAR     = 2'd3;

  // Counter kinds.
  localparam logic [2:0] KIND_CONN     = 3'd0;
  localparam logic [2:0] KIND_CONN_MAX = 3'd1;
  localparam logic [2:0] KIND_PLAN     = 3'd2;
  localparam logic [2:0] KIND_SEARCH   = 3'd3;
  localparam logic [2:0] KIND_DELETE   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_CONN     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_CONN_MAX = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_PLAN     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_SEARCH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_DELETE   = 3'd4;

  // Limit values after reset.
  localparam logic [LIMIT_W-1:0] RST_LIMIT_CONN     = 16'd300;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_CONN_MAX = 16'd1000;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_PLAN     = 16'd100;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_SEARCH   = 16'd200;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_DELETE   = 16'd300;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        kind;
    logic [ADDR_W-1:0] source_address;
  } psrl_in_t;

  typedef struct packed {
    logic                over_limit;
    logic                new_entry;
    logic                table_full;
    logic [UNIQUE_W-1:0] unique_count;
  } psrl_out_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] connection_count;
    logic [COUNT_W-1:0] plan_count;
    logic [COUNT_W-1:0] search_count;
    logic [COUNT_W-1:0] delete_count;
  } psrl_entry_t;

endpackage

### design/psrl_entry_ram.sv
// Entry memory: one write port and one registered read port.
module psrl_entry_ram #(
  parameter int unsigned DEPTH = psrl_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output psrl_pkg::psrl_entry_t      rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  psrl_pkg::psrl_entry_t      wr_data
);
  import psrl_pkg::*;

  psrl_entry_t mem [DEPTH];
  psrl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/per_source_request_limiter_unit.sv
// Per-source request limiter: a hashed table of IPv4 addresses with four counters each.
//
// Each request beat is looked up in a linearly probed hash table held in a single-port-read
// entry memory. Accepting a request in the idle state reads its home slot; the probe state
// then either finds the address, inserts it at an empty slot, flags a full table or reads
// the next slot, and the done state hands the result to the output register. The worst case,
// a full table, probes every slot. After reset the block sweeps the memory to mark every
// entry empty, and no request is taken during the sweep; a clear-table request runs the same
// sweep and delivers its result at the end of it. Configuration writes are always taken. A
// finished result waits in an output register, so the next request is accepted while the
// previous result is stalled.
module per_source_request_limiter_unit #(
  parameter int unsigned TABLE_ENTRIES = psrl_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  psrl_pkg::psrl_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output psrl_pkg::psrl_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psrl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [psrl_pkg::LIMIT_W-1:0]         cfg_data
);
  import psrl_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned TOTAL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   probe_cnt_r, probe_cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               clear_pending_r, clear_pending_nxt;
  logic               out_valid_r, out_valid_nxt;
  psrl_out_t          out_data_r, out_data_nxt;
  psrl_in_t           item_r, item_nxt;
  logic               over_r, over_nxt;
  logic               fresh_r, fresh_nxt;
  logic               full_r, full_nxt;

  logic [LIMIT_W-1:0] lim_conn_r, lim_conn_max_r, lim_plan_r, lim_search_r, lim_delete_r;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  psrl_entry_t        rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  psrl_entry_t        wr_data;

  logic [IDX_W-1:0]   hash_fold;
  logic [IDX_W-1:0]   hash_idx;
  logic [IDX_W-1:0]   next_idx;
  logic               accept;
  logic               out_free;
  logic               entry_hit;
  logic               kind_used;
  logic [COUNT_W-1:0] sel_count;
  logic [COUNT_W-1:0] new_count;
  logic [LIMIT_W-1:0] sel_limit;
  logic               do_inc;
  logic               do_check;
  psrl_entry_t        upd_entry;
  psrl_entry_t        fresh_entry;

  psrl_entry_ram #(
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_conn_r     <= RST_LIMIT_CONN;
      lim_conn_max_r <= RST_LIMIT_CONN_MAX;
      lim_plan_r     <= RST_LIMIT_PLAN;
      lim_search_r   <= RST_LIMIT_SEARCH;
      lim_delete_r   <= RST_LIMIT_DELETE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIMIT_CONN:     lim_conn_r     <= cfg_data;
        CFG_LIMIT_CONN_MAX: lim_conn_max_r <= cfg_data;
        CFG_LIMIT_PLAN:     lim_plan_r     <= cfg_data;
        CFG_LIMIT_SEARCH:   lim_search_r   <= cfg_data;
        CFG_LIMIT_DELETE:   lim_delete_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fold the address into an index, then bring it below the table size.
  always_comb begin
    hash_fold = '0;
    for (int j = 0; j < int'(ADDR_W); j += int'(IDX_W)) begin
      hash_fold = hash_fold ^ IDX_W'(in_data.source_address >> j);
    end
  end

  assign hash_idx = ({1'b0, hash_fold} >= (IDX_W + 1)'(TABLE_ENTRIES))
                    ? hash_fold - IDX_W'(TABLE_ENTRIES) : hash_fold;

  assign next_idx  = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign entry_hit = rd_data.valid && (rd_data.address == item_r.source_address);
  assign do_inc    = (item_r.action == ACT_INC) || (item_r.action == ACT_INC_CHECK);
  assign do_check  = (item_r.action == ACT_INC_CHECK) || (item_r.action == ACT_CHECK);

  always_comb begin
    kind_used = 1'b1;
    sel_count = rd_data.connection_count;
    sel_limit = lim_delete_r;
    unique case (item_r.kind)
      KIND_CONN: begin
        sel_limit = lim_conn_r;
      end
      KIND_CONN_MAX: begin
        sel_limit = lim_conn_max_r;
      end
      KIND_PLAN: begin
        sel_count = rd_data.plan_count;
        sel_limit = lim_plan_r;
      end
      KIND_SEARCH: begin
        sel_count = rd_data.search_count;
        sel_limit = lim_search_r;
      end
      KIND_DELETE: begin
        sel_count = rd_data.delete_count;
      end
      default: begin
        kind_used = 1'b0;
      end
    endcase
  end

  assign new_count = (do_inc && (sel_count != COUNT_MAX)) ? sel_count + 1'b1 : sel_count;

  always_comb begin
    upd_entry = rd_data;
    unique case (item_r.kind)
      KIND_CONN, KIND_CONN_MAX: upd_entry.connection_count = new_count;
      KIND_PLAN:                upd_entry.plan_count       = new_count;
      KIND_SEARCH:              upd_entry.search_count     = new_count;
      KIND_DELETE:              upd_entry.delete_count     = new_count;
      default: ;
    endcase
  end

  always_comb begin
    fresh_entry                  = '0;
    fresh_entry.valid            = 1'b1;
    fresh_entry.address          = item_r.source_address;
    fresh_entry.connection_count = COUNT_W'(1);
  end

  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    probe_cnt_nxt     = probe_cnt_r;
    total_nxt         = total_r;
    clear_pending_nxt = clear_pending_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_data_nxt      = out_data_r;
    item_nxt          = item_r;
    over_nxt          = over_r;
    fresh_nxt         = fresh_r;
    full_nxt          = full_r;
    rd_en             = 1'b0;
    rd_addr           = hash_idx;
    wr_en             = 1'b0;
    wr_addr           = idx_r;
    wr_data           = upd_entry;

    unique case (state_r)
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_data = '0;
        idx_nxt = next_idx;
        if (idx_r == LAST_IDX) begin
          clear_pending_nxt = 1'b0;
          state_nxt         = clear_pending_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          over_nxt  = 1'b0;
          fresh_nxt = 1'b0;
          full_nxt  = 1'b0;
          if (in_data.action == ACT_CLEAR) begin
            total_nxt         = '0;
            idx_nxt           = '0;
            clear_pending_nxt = 1'b1;
            state_nxt         = S_SWEEP;
          end else begin
            rd_en         = 1'b1;
            idx_nxt       = hash_idx;
            probe_cnt_nxt = '0;
            state_nxt     = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (!rd_data.valid) begin
          // Empty slot: the address is not stored anywhere, so it goes here.
          wr_en     = 1'b1;
          wr_data   = fresh_entry;
          total_nxt = total_r + 1'b1;
          fresh_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (entry_hit) begin
          wr_en     = kind_used;
          over_nxt  = kind_used && do_check && (new_count > sel_limit);
          state_nxt = S_DONE;
        end else if ((probe_cnt_r == LAST_IDX) || (total_r == FULL_TOTAL)
                     && (probe_cnt_r == LAST_IDX)) begin
          full_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = next_idx;
          idx_nxt       = next_idx;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.over_limit   = over_r;
          out_data_nxt.new_entry    = fresh_r;
          out_data_nxt.table_full   = full_r;
          out_data_nxt.unique_count = UNIQUE_W'(total_r);
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_SWEEP;
      idx_r           <= '0;
      probe_cnt_r     <= '0;
      total_r         <= '0;
      clear_pending_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      idx_r           <= idx_nxt;
      probe_cnt_r     <= probe_cnt_nxt;
      total_r         <= total_nxt;
      clear_pending_r <= clear_pending_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
    over_r     <= over_nxt;
    fresh_r    <= fresh_nxt;
    full_r     <= full_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
